// ===== sv/spf_pkg.sv =====
// Shared types, constants and the CRC byte update for the servo packet framer.
// No dependencies; every other file of the block imports this package.
package spf_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0]  HDR_BYTE0 = 8'hFF;
   localparam logic [7:0]  HDR_BYTE1 = 8'hFF;
   localparam logic [7:0]  HDR_BYTE2 = 8'hFD;
   localparam logic [7:0]  HDR_BYTE3 = 8'h00;
   localparam logic [15:0] CRC_POLY  = 16'h8005;
   localparam logic [15:0] CRC_INIT  = 16'h0000;

   // One classified body byte as it sits in the queue.
   typedef struct packed {
      logic [7:0] body_byte;
      logic       first;
      logic       last;
   } spf_entry_type;

   // Back-end sequencer phases, one-hot.
   typedef enum logic [6:0] {
      P_HDR0  = 7'b0000001,
      P_HDR1  = 7'b0000010,
      P_HDR2  = 7'b0000100,
      P_HDR3  = 7'b0001000,
      P_BODY  = 7'b0010000,
      P_CRCLO = 7'b0100000,
      P_CRCHI = 7'b1000000
   } spf_phase_type;

   // CRC-16, poly 0x8005, MSB first, one byte.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/spf_front.sv =====
// Front end of the framer: accepts body bytes and marks the first of each packet.
// Depends on spf_pkg.
module spf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_body_byte,
   input  logic                   req_body_last,
   input  logic                   q_full,
   output logic                   push,
   output spf_pkg::spf_entry_type push_entry
);
   import spf_pkg::*;

   logic inside_ff;
   logic inside_in;

   assign req_ready = !q_full;
   assign push      = req_valid && req_ready;

   assign push_entry.body_byte = req_body_byte;
   assign push_entry.first     = !inside_ff;
   assign push_entry.last      = req_body_last;

   always_comb begin
      inside_in = inside_ff;
      if (push) begin
         inside_in = !req_body_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
      end else begin
         inside_ff <= inside_in;
      end
   end

endmodule

// ===== sv/spf_queue.sv =====
// Small register FIFO between front and back end of the framer.
// Depends on spf_pkg. DEPTH must be a power of two, at least 2.
module spf_queue #(
   parameter int unsigned DEPTH = spf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  spf_pkg::spf_entry_type push_entry,
   input  logic                   pop,
   output spf_pkg::spf_entry_type head,
   output logic                   head_valid,
   output logic                   full
);
   import spf_pkg::*;

   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   spf_entry_type     mem_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== sv/spf_back.sv =====
// Back end of the framer: sequences header, body and CRC bytes into the output register.
// Depends on spf_pkg.
module spf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  spf_pkg::spf_entry_type head,
   input  logic                   head_valid,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_wire_byte,
   output logic                   rsp_frame_end
);
   import spf_pkg::*;

   spf_phase_type state_ff, state_in;
   logic [15:0]   crc_ff, crc_in;
   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff, byte_in;
   logic          end_ff, end_in;
   logic          advance;
   logic          counted;

   assign advance = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      byte_in  = head.body_byte;
      end_in   = 1'b0;
      counted  = 1'b0;
      pop      = 1'b0;
      crc_in   = crc_ff;
      case (state_ff)
         P_HDR0: begin
            if (head.first) begin
               byte_in  = HDR_BYTE0;
               counted  = 1'b1;
               state_in = P_HDR1;
            end else begin
               counted = 1'b1;
               if (head.last) begin
                  state_in = P_CRCLO;
               end else begin
                  pop = 1'b1;
               end
            end
         end
         P_HDR1: begin
            byte_in  = HDR_BYTE1;
            counted  = 1'b1;
            state_in = P_HDR2;
         end
         P_HDR2: begin
            byte_in  = HDR_BYTE2;
            counted  = 1'b1;
            state_in = P_HDR3;
         end
         P_HDR3: begin
            byte_in  = HDR_BYTE3;
            counted  = 1'b1;
            state_in = P_BODY;
         end
         P_BODY: begin
            counted = 1'b1;
            if (head.last) begin
               state_in = P_CRCLO;
            end else begin
               pop      = 1'b1;
               state_in = P_HDR0;
            end
         end
         P_CRCLO: begin
            byte_in  = crc_ff[7:0];
            state_in = P_CRCHI;
         end
         P_CRCHI: begin
            byte_in  = crc_ff[15:8];
            end_in   = 1'b1;
            pop      = 1'b1;
            crc_in   = CRC_INIT;
            state_in = P_HDR0;
         end
         default: begin
            state_in = P_HDR0;
         end
      endcase
      if (counted) begin
         crc_in = crc_feed(crc_ff, byte_in);
      end
      if (!advance) begin
         state_in = state_ff;
         crc_in   = crc_ff;
         pop      = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_HDR0;
         crc_ff   <= CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         end_ff  <= end_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_wire_byte = byte_ff;
   assign rsp_frame_end = end_ff;

endmodule

// ===== sv/servo_packet_framer_crc16.sv =====
// Top level of the servo packet framer with CRC-16 trailer.
// Depends on spf_pkg, spf_front, spf_queue and spf_back.
//
// Takes a packet body one byte per transfer (req_body_last on the final byte) and
// sends out the framed packet one byte per transfer: header FF FF FD 00, the body
// bytes unchanged, then CRC low and CRC high (rsp_frame_end set on the high byte).
// CRC-16 poly 0x8005, MSB first, init 0, no final xor, over header and body; no
// byte stuffing. Rate: one output byte per cycle while rsp_ready is high and the queue
// holds an entry, from a single-byte sequencer; a middle body byte gives one output
// byte, a first byte five and a last byte three, so a packet of N body bytes gives
// N + 6 output bytes. The front accepts a byte per cycle while the QUEUE_DEPTH-entry
// queue (power of two, 2 or more) has room, so the sender keeps going during the header
// and CRC bytes until it fills. Each byte is held in the queue, then in the output register.
module servo_packet_framer_crc16 #(
   parameter int unsigned QUEUE_DEPTH = spf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_body_byte,
   input  logic       req_body_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_wire_byte,
   output logic       rsp_frame_end
);
   import spf_pkg::*;

   spf_entry_type push_entry;
   spf_entry_type head;
   logic          push;
   logic          pop;
   logic          head_valid;
   logic          q_full;

   // front: handshake and first-byte marking
   spf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_body_byte (req_body_byte),
      .req_body_last (req_body_last),
      .q_full        (q_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   // decoupling queue
   spf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   // back: header / body / CRC sequencer and output register
   spf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_valid    (head_valid),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_wire_byte (rsp_wire_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== sv/spf_checker.sv =====
// Port-level checks for the servo packet framer, bound to the top level.
// Depends on spf_pkg and servo_packet_framer_crc16.
module spf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_wire_byte,
   input logic       rsp_frame_end
);
   import spf_pkg::*;

   // position within the header of the packet being sent, 4 = past header
   logic [2:0] pos_ff, pos_in;

   always_comb begin
      pos_in = pos_ff;
      if (rsp_valid && rsp_ready) begin
         if (rsp_frame_end) begin
            pos_in = 3'd0;
         end else if (pos_ff < 3'd4) begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 3'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // queue is empty straight after reset, so the input must be open
   a_ready_after_reset: assert property (@(posedge clock) reset |=> req_ready)
      else $error("req_ready low after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_wire_byte)
                                  && $stable(rsp_frame_end))
      else $error("stalled transfer changed");

   a_header_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pos_ff == 3'd0 && rsp_wire_byte == HDR_BYTE0)
                 || (pos_ff == 3'd1 && rsp_wire_byte == HDR_BYTE1)
                 || (pos_ff == 3'd2 && rsp_wire_byte == HDR_BYTE2)
                 || (pos_ff == 3'd3 && rsp_wire_byte == HDR_BYTE3)
                 || (pos_ff == 3'd4))
      else $error("wrong header byte");

   a_no_end_in_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pos_ff < 3'd4 |-> !rsp_frame_end)
      else $error("frame end inside header");

endmodule

bind servo_packet_framer_crc16 spf_checker u_spf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_wire_byte (rsp_wire_byte),
   .rsp_frame_end (rsp_frame_end)
);
